// ===== hdl/fpe_pkg.sv =====
`timescale 1ns / 1ps

package fpe_pkg;

  localparam int unsigned COUNT_W = 31;
  localparam int unsigned DIGITS  = 10;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // n / 10 == (n * RECIP_10) >> 35 for every 32-bit n
  localparam logic [31:0] RECIP_10 = 32'hCCCC_CCCD;

  localparam logic [2:0] KIND_FMT   = 3'd0;
  localparam logic [2:0] KIND_WORD  = 3'd1;
  localparam logic [2:0] KIND_SBYTE = 3'd2;
  localparam logic [2:0] KIND_EMPTY = 3'd3;
  localparam logic [2:0] KIND_NULL  = 3'd4;
  localparam logic [2:0] KIND_START = 3'd5;

  localparam logic [1:0] ARG_NONE = 2'd0;
  localparam logic [1:0] ARG_STR  = 2'd1;
  localparam logic [1:0] ARG_DEC  = 2'd2;
  localparam logic [1:0] ARG_HEX  = 2'd3;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_S       = 8'h73;
  localparam logic [7:0] CH_D       = 8'h64;
  localparam logic [7:0] CH_X       = 8'h78;
  localparam logic [7:0] CH_MINUS   = 8'h2D;

  typedef enum logic [2:0] {
    OP_DISPATCH,
    OP_EMIT_BYTE,
    OP_EMIT_NULL,
    OP_SIGN,
    OP_MUL,
    OP_DIV,
    OP_HEX,
    OP_EMIT_DIGIT
  } op_t;

  typedef logic [2:0] step_t;

  localparam step_t ST_IDLE = 3'd0;
  localparam step_t ST_ECHO = 3'd1;
  localparam step_t ST_NULL = 3'd2;
  localparam step_t ST_SIGN = 3'd3;
  localparam step_t ST_MUL  = 3'd4;
  localparam step_t ST_DIV  = 3'd5;
  localparam step_t ST_HEX  = 3'd6;
  localparam step_t ST_OUT  = 3'd7;

  // jmp is taken when the step's condition holds, nxt otherwise
  typedef struct packed {
    op_t   op;
    step_t jmp;
    step_t nxt;
  } uword_t;

  function automatic uword_t ucode(input step_t s);
    uword_t w;
    case (s)
      ST_IDLE: w = '{op: OP_DISPATCH,   jmp: ST_IDLE, nxt: ST_IDLE};
      ST_ECHO: w = '{op: OP_EMIT_BYTE,  jmp: ST_IDLE, nxt: ST_IDLE};
      ST_NULL: w = '{op: OP_EMIT_NULL,  jmp: ST_NULL, nxt: ST_IDLE};
      ST_SIGN: w = '{op: OP_SIGN,       jmp: ST_MUL,  nxt: ST_MUL};
      ST_MUL:  w = '{op: OP_MUL,        jmp: ST_DIV,  nxt: ST_DIV};
      ST_DIV:  w = '{op: OP_DIV,        jmp: ST_MUL,  nxt: ST_OUT};
      ST_HEX:  w = '{op: OP_HEX,        jmp: ST_HEX,  nxt: ST_OUT};
      ST_OUT:  w = '{op: OP_EMIT_DIGIT, jmp: ST_OUT,  nxt: ST_IDLE};
      default: w = '{op: OP_DISPATCH,   jmp: ST_IDLE, nxt: ST_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = 8'h30 + {4'b0, d};
    end else begin
      c = 8'h57 + {4'b0, d};
    end
    return c;
  endfunction

  function automatic logic [7:0] null_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0:    c = 8'h28;
      3'd1:    c = 8'h6E;
      3'd2:    c = 8'h75;
      3'd3:    c = 8'h6C;
      3'd4:    c = 8'h6C;
      3'd5:    c = 8'h29;
      default: c = 8'h29;
    endcase
    return c;
  endfunction

endpackage

// ===== hdl/format_print_engine.sv =====
`timescale 1ns / 1ps
// An item is taken at the idle step; plain and string bytes reach the output register from the
// echo step, a decimal word through the sign, multiply, divide and digit steps in that order.
// One item at a time: a new item is taken only once the routine for the last one is back at
// idle. A null string is emitted from the null step, a hex word runs the hex and digit steps,
// and an output stall holds the current step.
// Reset (rst, synchronous, active high) clears the step counter, pending state and count.

module format_print_engine
  import fpe_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         kind,
  input  logic [31:0]        data,
  input  logic               string_end,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_char,
  output logic               last,
  output logic [COUNT_W-1:0] char_count
);

  // sequencer
  step_t  pc;
  uword_t uw;

  // format state
  logic       percent_pending;
  logic [1:0] awaited;
  logic [COUNT_W-1:0] count;

  // datapath: working word, product register, digit stack (newest digit at entry 0),
  // digit count
  logic [31:0] mag;
  logic [63:0] prod;
  logic [3:0]  dig_buf [DIGITS];
  logic [3:0]  len;

  logic [3:0]  len_m1;
  logic [31:0] quot;
  logic [31:0] quot10;
  logic [3:0]  digit;

  logic       accept;
  logic       emit_ok;
  logic       do_emit;
  logic       fire;
  logic       stall;
  logic       cond;
  logic [7:0] emit_char;
  logic       emit_last;
  logic [COUNT_W-1:0] count_inc;

  // dispatch decode
  step_t      disp_step;
  logic       pend_next;
  logic [1:0] await_next;
  logic       start;

  logic [7:0] byte_in;

  assign uw       = ucode(pc);
  assign in_ready = (uw.op == OP_DISPATCH);
  assign accept   = in_valid && in_ready;
  assign byte_in  = data[7:0];

  assign len_m1 = len - 4'd1;
  assign quot   = {3'b0, prod[63:35]};
  assign quot10 = {quot[28:0], 3'b0} + {quot[30:0], 1'b0};
  assign digit  = 4'(mag - quot10);

  assign emit_ok   = !out_valid || out_ready;
  assign count_inc = (count == COUNT_MAX) ? count : count + 1'b1;

  // per-step control: what the current step emits and which way it branches
  always_comb begin
    do_emit   = 1'b0;
    emit_char = mag[7:0];
    emit_last = 1'b1;
    cond      = 1'b0;
    case (uw.op)
      OP_DISPATCH: begin
      end
      OP_EMIT_BYTE: begin
        do_emit = 1'b1;
      end
      OP_EMIT_NULL: begin
        do_emit   = 1'b1;
        emit_char = null_char(len[2:0]);
        emit_last = (len == 4'd5);
        cond      = (len != 4'd5);
      end
      OP_SIGN: begin
        do_emit   = mag[31];
        emit_char = CH_MINUS;
        emit_last = 1'b0;
      end
      OP_MUL: begin
      end
      OP_DIV: begin
        cond = (quot != 32'd0) && (len < 4'(DIGITS - 1));
      end
      OP_HEX: begin
        cond = (mag[31:4] != 28'd0) && (len < 4'd7);
      end
      OP_EMIT_DIGIT: begin
        do_emit   = 1'b1;
        emit_char = hex_char(dig_buf[0]);
        emit_last = (len == 4'd1);
        cond      = (len != 4'd1);
      end
      default: begin
      end
    endcase
  end

  assign stall = do_emit && !emit_ok;
  assign fire  = do_emit && emit_ok;

  // item decode at the idle step: state changes and entry point of the routine
  always_comb begin
    disp_step  = ST_IDLE;
    pend_next  = percent_pending;
    await_next = awaited;
    start      = 1'b0;
    case (kind)
      KIND_FMT: begin
        if (awaited == ARG_NONE && byte_in != 8'd0) begin
          if (percent_pending) begin
            pend_next = 1'b0;
            if (byte_in == CH_S) begin
              await_next = ARG_STR;
            end else if (byte_in == CH_D) begin
              await_next = ARG_DEC;
            end else if (byte_in == CH_X) begin
              await_next = ARG_HEX;
            end
          end else if (byte_in == CH_PERCENT) begin
            pend_next = 1'b1;
          end else begin
            disp_step = ST_ECHO;
          end
        end
      end
      KIND_WORD: begin
        if (awaited == ARG_DEC) begin
          disp_step  = ST_SIGN;
          await_next = ARG_NONE;
        end else if (awaited == ARG_HEX) begin
          disp_step  = ST_HEX;
          await_next = ARG_NONE;
        end
      end
      KIND_SBYTE: begin
        if (awaited == ARG_STR) begin
          if (byte_in == 8'd0) begin
            await_next = ARG_NONE;
          end else begin
            disp_step = ST_ECHO;
            if (string_end) begin
              await_next = ARG_NONE;
            end
          end
        end
      end
      KIND_EMPTY: begin
        if (awaited == ARG_STR) begin
          await_next = ARG_NONE;
        end
      end
      KIND_NULL: begin
        if (awaited == ARG_STR) begin
          disp_step  = ST_NULL;
          await_next = ARG_NONE;
        end
      end
      KIND_START: begin
        start      = 1'b1;
        pend_next  = 1'b0;
        await_next = ARG_NONE;
      end
      default: begin
      end
    endcase
  end

  // step counter and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      pc              <= ST_IDLE;
      percent_pending <= 1'b0;
      awaited         <= ARG_NONE;
      count           <= '0;
      len             <= 4'd0;
    end else begin
      if (uw.op == OP_DISPATCH) begin
        if (accept) begin
          pc              <= disp_step;
          percent_pending <= pend_next;
          awaited         <= await_next;
          len             <= 4'd0;
          if (start) begin
            count <= '0;
          end
        end
      end else if (!stall) begin
        pc <= cond ? uw.jmp : uw.nxt;
        case (uw.op)
          OP_EMIT_NULL:  len <= len + 4'd1;
          OP_DIV:        len <= len + 4'd1;
          OP_HEX:        len <= len + 4'd1;
          OP_EMIT_DIGIT: len <= len_m1;
          default: begin
          end
        endcase
      end
      if (fire) begin
        count <= count_inc;
      end
    end
  end

  // working word, product and digit stack; digits go in least significant first
  // and come out from entry 0, so the stack shifts up on a push and down on a pop
  always_ff @(posedge clk) begin
    if (accept) begin
      mag <= data;
    end else if (!stall) begin
      case (uw.op)
        OP_SIGN: begin
          if (mag[31]) begin
            mag <= ~mag + 32'd1;
          end
        end
        OP_MUL: begin
          prod <= mag * RECIP_10;
        end
        OP_DIV: begin
          dig_buf[0] <= digit;
          for (int i = 1; i < DIGITS; i++) begin
            dig_buf[i] <= dig_buf[i-1];
          end
          mag <= quot;
        end
        OP_HEX: begin
          dig_buf[0] <= mag[3:0];
          for (int i = 1; i < DIGITS; i++) begin
            dig_buf[i] <= dig_buf[i-1];
          end
          mag <= {4'b0, mag[31:4]};
        end
        OP_EMIT_DIGIT: begin
          for (int i = 0; i < DIGITS - 1; i++) begin
            dig_buf[i] <= dig_buf[i+1];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_char   <= emit_char;
      last       <= emit_last;
      char_count <= count_inc;
    end
  end

endmodule

// ===== hdl/fpe_checker.sv =====
`timescale 1ns / 1ps

module fpe_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic [2:0]  kind,
  input logic [31:0] data,
  input logic        string_end,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_char,
  input logic        last,
  input logic [30:0] char_count
);

  // a waiting item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(last)
      && $stable(char_count))
    else $error("output item changed while stalled");

  // every delivered character has been counted
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> char_count != 31'd0)
    else $error("character delivered with zero count");

  // no new item is taken while the current one still has characters to come
  a_no_take_mid_item: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> !in_ready)
    else $error("input taken before the last character of an item");

  // consecutive characters of one item count up by one unless saturated
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last && char_count != 31'h7FFF_FFFF ##1 out_valid
      |-> char_count == $past(char_count) + 31'd1 || !$rose(out_valid) && !$changed(char_count))
    else $error("character count did not advance");

endmodule

bind format_print_engine fpe_checker u_fpe_checker (.*);

// ===== verif/format_print_checker.sv =====
`timescale 1ns / 1ps

module format_print_checker
  import fpe_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [2:0]         kind,
  input  logic [31:0]        data,
  input  logic               string_end,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [7:0]         out_char,
  input  logic               last,
  input  logic [COUNT_W-1:0] char_count,
  output int                 mismatches,
  output int                 chars_due,
  output int                 chars_seen
);

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_A_LOW = 8'h61;
  localparam int         SHOW_MAX = 30;

  typedef struct packed {
    logic [7:0]         ch;
    logic               fin;
    logic [COUNT_W-1:0] cnt;
  } char_rec_t;

  char_rec_t          due_chars[$];
  logic [7:0]         burst[$];
  logic               pct_armed;
  logic [1:0]         awaiting;
  logic [COUNT_W-1:0] tally;
  string              null_text;
  char_rec_t          head;

  initial begin
    mismatches = 0;
    chars_due  = 0;
    chars_seen = 0;
    null_text  = "(null)";
    pct_armed  = 1'b0;
    awaiting   = ARG_NONE;
    tally      = '0;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    mismatches++;
    if (mismatches <= SHOW_MAX) begin
      $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
    end
  endtask

  function automatic void spell_decimal(input logic [31:0] w);
    logic [31:0] mag;
    logic [31:0] dig;
    logic [7:0]  rev [0:9];
    int          n;
    mag = w;
    if (w[31]) begin
      burst.push_back(CH_MINUS);
      mag = 32'd0 - w;
    end
    n = 0;
    do begin
      dig    = mag % 10;
      rev[n] = CH_ZERO + dig[7:0];
      mag    = mag / 10;
      n++;
    end while (mag != 0);
    while (n > 0) begin
      n--;
      burst.push_back(rev[n]);
    end
  endfunction

  function automatic void spell_hex(input logic [31:0] w);
    logic [31:0] rest;
    logic [7:0]  nib;
    logic [7:0]  rev [0:7];
    int          n;
    rest = w;
    n    = 0;
    do begin
      nib    = {4'h0, rest[3:0]};
      rev[n] = (nib < 8'd10) ? CH_ZERO + nib : CH_A_LOW + nib - 8'd10;
      rest   = rest >> 4;
      n++;
    end while (rest != 0);
    while (n > 0) begin
      n--;
      burst.push_back(rev[n]);
    end
  endfunction

  // Works out the characters one accepted item produces and queues them.
  function automatic void format_item(input logic [2:0] k, input logic [31:0] d,
                                      input logic e);
    logic [7:0] b;
    char_rec_t  rec;
    int         i;
    b = d[7:0];
    burst.delete();
    case (k)
      KIND_FMT: begin
        if (awaiting == ARG_NONE && b != 8'h00) begin
          if (pct_armed) begin
            pct_armed = 1'b0;
            if (b == CH_S) awaiting = ARG_STR;
            else if (b == CH_D) awaiting = ARG_DEC;
            else if (b == CH_X) awaiting = ARG_HEX;
          end else if (b == CH_PERCENT) begin
            pct_armed = 1'b1;
          end else begin
            burst.push_back(b);
          end
        end
      end
      KIND_WORD: begin
        if (awaiting == ARG_DEC) begin
          spell_decimal(d);
          awaiting = ARG_NONE;
        end else if (awaiting == ARG_HEX) begin
          spell_hex(d);
          awaiting = ARG_NONE;
        end
      end
      KIND_SBYTE: begin
        if (awaiting == ARG_STR) begin
          if (b == 8'h00) begin
            awaiting = ARG_NONE;
          end else begin
            burst.push_back(b);
            if (e) awaiting = ARG_NONE;
          end
        end
      end
      KIND_EMPTY: begin
        if (awaiting == ARG_STR) awaiting = ARG_NONE;
      end
      KIND_NULL: begin
        if (awaiting == ARG_STR) begin
          for (i = 0; i < 6; i++) burst.push_back(null_text[i]);
          awaiting = ARG_NONE;
        end
      end
      KIND_START: begin
        pct_armed = 1'b0;
        awaiting  = ARG_NONE;
        tally     = '0;
      end
      default: begin
      end
    endcase
    for (i = 0; i < burst.size(); i++) begin
      if (tally != COUNT_MAX) tally = tally + 1'b1;
      rec.ch  = burst[i];
      rec.fin = (i == burst.size() - 1);
      rec.cnt = tally;
      due_chars.push_back(rec);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      pct_armed = 1'b0;
      awaiting  = ARG_NONE;
      tally     = '0;
      due_chars.delete();
    end else begin
      if (in_valid && in_ready) format_item(kind, data, string_end);
      if (out_valid && out_ready) begin
        chars_seen++;
        if (due_chars.size() == 0) begin
          report("character with none due", {24'h0, out_char}, 32'h0);
        end else begin
          head = due_chars.pop_front();
          if (out_char !== head.ch) report("out_char", {24'h0, out_char}, {24'h0, head.ch});
          if (last !== head.fin) report("last", {31'h0, last}, {31'h0, head.fin});
          if (char_count !== head.cnt) report("char_count", {1'b0, char_count}, {1'b0, head.cnt});
        end
      end
    end
    chars_due = due_chars.size();
  end

endmodule

// ===== verif/format_print_engine_tb.sv =====
`timescale 1ns / 1ps

module format_print_engine_tb
  import fpe_pkg::*;
;

  // unused kind codes: the block must drop them
  localparam logic [2:0] KIND_SPARE6 = 3'd6;
  localparam logic [2:0] KIND_SPARE7 = 3'd7;

  localparam int IDLE_PCT      = 13;
  localparam int SETTLE_CYCLES = 30;      // covers the slowest item up to its first character
  localparam int HOLD_CYCLES   = 400;     // long enough for the block to back up
  localparam int CYCLE_LIMIT   = 400000;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         kind;
  logic [31:0]        data;
  logic               string_end;
  logic               out_valid;
  logic               out_ready;
  logic [7:0]         out_char;
  logic               last;
  logic [COUNT_W-1:0] char_count;

  int mismatches;
  int chars_due;
  int chars_seen;
  int items_sent;
  int hold_asked;
  int hold_served;
  int cycles;
  bit calm;             // set for the stretch where neither side idles

  format_print_engine DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .data       (data),
    .string_end (string_end),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_char   (out_char),
    .last       (last),
    .char_count (char_count)
  );

  // Watches both channels, predicts every character and compares.
  format_print_checker u_chars (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .data       (data),
    .string_end (string_end),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_char   (out_char),
    .last       (last),
    .char_count (char_count),
    .mismatches (mismatches),
    .chars_due  (chars_due),
    .chars_seen (chars_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hang or a lost character ends the run here.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver. Randomly backs off, except in the calm stretch; when the stimulus
  // asks for a hold-off it drops ready for a long, self-counted run of cycles.
  initial begin
    hold_served = 0;
    out_ready   = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_asked) begin
        hold_served++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Offers one item and returns at the edge where it is taken. A random gap may
  // come first; valid then stays high with the payload steady until accepted.
  task automatic send(input logic [2:0] k, input logic [31:0] d, input logic e);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= k;
    data       <= d;
    string_end <= e;
    items_sent++;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  // Format byte with junk in the ignored upper bits and in string_end.
  task automatic fmt(input logic [7:0] c);
    logic [31:0] w;
    w      = $urandom;
    w[7:0] = c;
    send(KIND_FMT, w, 1'($urandom_range(1)));
  endtask

  task automatic spec(input logic [7:0] c);
    fmt(CH_PERCENT);
    fmt(c);
  endtask

  task automatic string_byte(input logic [7:0] c, input logic e);
    logic [31:0] w;
    w      = $urandom;
    w[7:0] = c;
    send(KIND_SBYTE, w, e);
  endtask

  task automatic word(input logic [31:0] w);
    send(KIND_WORD, w, 1'($urandom_range(1)));
  endtask

  // Sender pause: drop valid, let every due character come out, then allow
  // for an item still being worked on that produces nothing.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (chars_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == CH_PERCENT);
    return b;
  endfunction

  // Mix of small values, negatives, full-range and the boundary words.
  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    case ($urandom_range(3))
      0: w = $urandom;
      1: w = $urandom_range(0, 99);
      2: begin
        w = $urandom_range(1, 99);
        w = 32'd0 - w;
      end
      default: begin
        case ($urandom_range(3))
          0: w = 32'h0000_0000;
          1: w = 32'h8000_0000;
          2: w = 32'h7FFF_FFFF;
          default: w = 32'hFFFF_FFFF;
        endcase
      end
    endcase
    return w;
  endfunction

  // One random fragment of a format stream. Mostly plain bytes and well-formed conversions with
  // random content, the rest stray specifiers, noise items and restarts.
  task automatic random_piece();
    int pick;
    int mode;
    int n;
    int i;
    pick = $urandom_range(99);
    if (pick < 35) begin
      n = $urandom_range(1, 3);
      repeat (n) fmt(plain_byte());
    end else if (pick < 52) begin
      spec(CH_D);
      word(rand_word());
    end else if (pick < 64) begin
      spec(CH_X);
      word(rand_word());
    end else if (pick < 80) begin
      spec(CH_S);
      mode = $urandom_range(5);
      if (mode == 0) begin
        send(KIND_NULL, $urandom, 1'($urandom_range(1)));
      end else if (mode == 1) begin
        send(KIND_EMPTY, $urandom, 1'($urandom_range(1)));
      end else begin
        n = $urandom_range(1, 5);
        for (i = 0; i < n; i++) string_byte(plain_byte(), mode != 2 && i == n - 1);
        // mode 2 ends the string on a zero byte instead of a marked one
        if (mode == 2) string_byte(8'h00, 1'($urandom_range(1)));
      end
    end else if (pick < 88) begin
      case ($urandom_range(2))
        0: spec(CH_PERCENT);
        1: spec(8'h00);
        default: spec(plain_byte());
      endcase
    end else if (pick < 97) begin
      send(3'($urandom_range(7)), $urandom, 1'($urandom_range(1)));
    end else begin
      send(KIND_START, $urandom, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    kind       = KIND_FMT;
    data       = 32'h0;
    string_end = 1'b0;
    calm       = 1'b0;
    items_sent = 0;
    hold_asked = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part
    send(KIND_FMT, 32'hFFFF_FFFF, 1'b1);   // top byte value echoed, all data bits set
    spec(CH_D);
    word(32'h8000_0000);                   // most negative word
    spec(CH_X);
    fmt(8'h5A);                            // format byte while a word is awaited: dropped
    word(32'hFFFF_FFFF);
    spec(CH_D);
    word(32'h0000_0000);                   // zero prints a single digit
    spec(CH_S);
    send(KIND_NULL, 32'h0, 1'b0);          // null string
    spec(CH_S);
    string_byte(8'h68, 1'b0);
    string_byte(8'h69, 1'b1);              // byte marked last closes the string
    spec(CH_S);
    string_byte(8'h00, 1'b0);              // zero byte closes it silently
    spec(CH_S);
    send(KIND_EMPTY, 32'h0, 1'b0);
    fmt(CH_PERCENT);
    fmt(8'h00);                            // zero byte leaves the '%' armed
    fmt(CH_PERCENT);                       // '%%' prints nothing
    word(32'h0000_0005);                   // word with nothing awaited
    send(KIND_SPARE6, 32'hFFFF_FFFF, 1'b1);
    send(KIND_SPARE7, 32'h0, 1'b0);
    fmt(CH_PERCENT);
    send(KIND_START, 32'h0, 1'b0);         // start clears the armed '%' and the count
    fmt(CH_PERCENT);                       // trailing '%'
    wait_drained();

    // Random part: ordinary idling first
    while (items_sent < 170) random_piece();

    // Long stretch with no idling on either side
    calm = 1'b1;
    while (items_sent < 240) random_piece();
    calm = 1'b0;

    // Receiver holds off while items keep coming, so the block backs up
    hold_asked++;
    while (items_sent < 280) random_piece();
    wait_drained();

    while (items_sent < 350) random_piece();
    wait_drained();

    $display("Ran %0d items: directed edge cases, then random format streams;", items_sent);
    $display("checked %0d characters with idling, a calm stretch, a long hold-off and drains.",
             chars_seen);
    if (mismatches == 0 && chars_due == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
